FILE: rtl/rtcwt_pkg.sv
// ----------------------------------------------------------------------------
// rtcwt_pkg
// Shared types, codes and limits of the calendar clock with wake timer.
// ----------------------------------------------------------------------------
package rtcwt_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_BUTTON = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;
  localparam logic [1:0] OP_ACK    = 2'd3;

  localparam logic [1:0] WAKE_OFF   = 2'd0;
  localparam logic [1:0] WAKE_AWAKE = 2'd1;
  localparam logic [1:0] WAKE_JUST  = 2'd2;

  localparam logic [7:0] WAKE_JUST_WOKE = 8'hFF;
  localparam logic [7:0] WAKE_MAX_RST   = 8'd8;
  localparam logic [7:0] WAKE_MAX_LO    = 8'd1;
  localparam logic [7:0] WAKE_MAX_HI    = 8'd254;
  localparam logic [7:0] WAKE_TIMER_RST = 8'd8;

  localparam logic [5:0] SEC_MAX       = 6'd59;
  localparam logic [5:0] MIN_MAX       = 6'd59;
  localparam logic [4:0] HOUR_MAX      = 5'd23;
  localparam logic [2:0] WDAY_MAX      = 3'd6;
  localparam logic [4:0] DAY_MIN       = 5'd1;
  localparam logic [4:0] DAY_MAX       = 5'd31;
  localparam logic [3:0] MONTH_MAX     = 4'd11;
  localparam logic [6:0] YEAR_MAX      = 7'd99;
  localparam logic [3:0] MONTH_FEB     = 4'd1;
  localparam logic [4:0] FEB_DAYS      = 5'd28;
  localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [2:0] wday;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } cal_time_t;

  typedef struct packed {
    logic       en;
    logic [1:0] op;
  } cmd_t;

  localparam cal_time_t CAL_RST = '{
    sec: 6'd0, min: 6'd40, hour: 5'd14, wday: 3'd5,
    day: 5'd23, month: 4'd2, year: 7'd22
  };

  function automatic logic [4:0] month_len(input logic [3:0] month,
                                           input logic [6:0] year);
    logic [4:0] len;
    case (month)
      4'd1:    len = (year[1:0] == 2'd0) ? FEB_LEAP_DAYS : FEB_DAYS;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/rtcwt_calendar.sv
// ----------------------------------------------------------------------------
// rtcwt_calendar
// Time and date counters: one-second advance with carry chain, and load.
// ----------------------------------------------------------------------------
module rtcwt_calendar (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtcwt_pkg::cmd_t       cmd,
  input  rtcwt_pkg::cal_time_t  load,
  output rtcwt_pkg::cal_time_t  cal_nxt
);

  rtcwt_pkg::cal_time_t cal_r;
  logic [4:0]           mlen;

  assign mlen = rtcwt_pkg::month_len(cal_r.month, cal_r.year);

  always_comb begin
    cal_nxt = cal_r;
    case (cmd.op)
      rtcwt_pkg::OP_TICK: begin
        if (cal_r.sec != rtcwt_pkg::SEC_MAX) begin
          cal_nxt.sec = cal_r.sec + 6'd1;
        end else begin
          cal_nxt.sec = '0;
          if (cal_r.min != rtcwt_pkg::MIN_MAX) begin
            cal_nxt.min = cal_r.min + 6'd1;
          end else begin
            cal_nxt.min = '0;
            if (cal_r.hour != rtcwt_pkg::HOUR_MAX) begin
              cal_nxt.hour = cal_r.hour + 5'd1;
            end else begin
              cal_nxt.hour = '0;
              cal_nxt.wday = (cal_r.wday == rtcwt_pkg::WDAY_MAX) ? 3'd0 : cal_r.wday + 3'd1;
              if (cal_r.day < mlen) begin
                cal_nxt.day = cal_r.day + 5'd1;
              end else begin
                cal_nxt.day = rtcwt_pkg::DAY_MIN;
                if (cal_r.month != rtcwt_pkg::MONTH_MAX) begin
                  cal_nxt.month = cal_r.month + 4'd1;
                end else begin
                  cal_nxt.month = '0;
                  cal_nxt.year  = (cal_r.year >= rtcwt_pkg::YEAR_MAX) ? 7'd0
                                                                      : cal_r.year + 7'd1;
                end
              end
            end
          end
        end
      end
      rtcwt_pkg::OP_LOAD: begin
        cal_nxt.hour  = (load.hour > rtcwt_pkg::HOUR_MAX) ? rtcwt_pkg::HOUR_MAX : load.hour;
        cal_nxt.min   = (load.min > rtcwt_pkg::MIN_MAX) ? rtcwt_pkg::MIN_MAX : load.min;
        cal_nxt.sec   = (load.sec > rtcwt_pkg::SEC_MAX) ? rtcwt_pkg::SEC_MAX : load.sec;
        cal_nxt.wday  = (load.wday > rtcwt_pkg::WDAY_MAX) ? rtcwt_pkg::WDAY_MAX : load.wday;
        cal_nxt.day   = (load.day < rtcwt_pkg::DAY_MIN) ? rtcwt_pkg::DAY_MIN : load.day;
        cal_nxt.month = (load.month > rtcwt_pkg::MONTH_MAX) ? rtcwt_pkg::MONTH_MAX
                                                            : load.month;
        cal_nxt.year  = (load.year > rtcwt_pkg::YEAR_MAX) ? rtcwt_pkg::YEAR_MAX : load.year;
      end
      default: begin
        cal_nxt = cal_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= rtcwt_pkg::CAL_RST;
    end else if (cmd.en) begin
      cal_r <= cal_nxt;
    end
  end

endmodule

FILE: rtl/rtcwt_wake.sv
// ----------------------------------------------------------------------------
// rtcwt_wake
// Display wake timer and its timeout register.
// ----------------------------------------------------------------------------
module rtcwt_wake (
  input  logic            clk,
  input  logic            rst_n,
  input  rtcwt_pkg::cmd_t cmd,
  input  logic            cfg_wr_en,
  input  logic [7:0]      cfg_wr_data,
  output logic [7:0]      timer_nxt
);

  logic [7:0] wake_max_r;
  logic [7:0] wake_max_nxt;
  logic [7:0] timer_r;

  always_comb begin
    if (cfg_wr_data < rtcwt_pkg::WAKE_MAX_LO) begin
      wake_max_nxt = rtcwt_pkg::WAKE_MAX_LO;
    end else if (cfg_wr_data > rtcwt_pkg::WAKE_MAX_HI) begin
      wake_max_nxt = rtcwt_pkg::WAKE_MAX_HI;
    end else begin
      wake_max_nxt = cfg_wr_data;
    end
  end

  always_comb begin
    timer_nxt = timer_r;
    case (cmd.op)
      rtcwt_pkg::OP_TICK: begin
        if (timer_r != 8'd0 && timer_r <= wake_max_r) begin
          timer_nxt = timer_r - 8'd1;
        end
      end
      rtcwt_pkg::OP_BUTTON: begin
        timer_nxt = (timer_r == 8'd0) ? rtcwt_pkg::WAKE_JUST_WOKE : wake_max_r;
      end
      rtcwt_pkg::OP_ACK: begin
        if (timer_r == rtcwt_pkg::WAKE_JUST_WOKE) begin
          timer_nxt = wake_max_r;
        end
      end
      default: begin
        timer_nxt = timer_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wake_max_r <= rtcwt_pkg::WAKE_MAX_RST;
      timer_r    <= rtcwt_pkg::WAKE_TIMER_RST;
    end else begin
      if (cfg_wr_en) begin
        wake_max_r <= wake_max_nxt;
      end
      if (cmd.en) begin
        timer_r <= timer_nxt;
      end
    end
  end

endmodule

FILE: rtl/rtc_calendar_with_wake_timer.sv
// ----------------------------------------------------------------------------
// rtc_calendar_with_wake_timer
// Calendar clock advanced by tick requests, with a display wake timer.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   in_opcode, in_load_*
//   out      out_valid / out_stall out_second .. out_year, out_wake_*
//   cfg      cfg_wr_en             cfg_wr_data (wake timeout)
//
// One request per cycle sustained while out_stall is low; an accepted request
// passes the input register, then the counter update and result register.
// Counter and timer state changes as a request leaves the input register.
// Out stall holds the result register; the input register still takes one
// more request before in_stall rises.
// Reset is synchronous and restores the power-on time and timeout.
// ----------------------------------------------------------------------------
module rtc_calendar_with_wake_timer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [4:0] in_load_hour,
  input  logic [5:0] in_load_minute,
  input  logic [5:0] in_load_second,
  input  logic [2:0] in_load_weekday,
  input  logic [4:0] in_load_day,
  input  logic [3:0] in_load_month,
  input  logic [6:0] in_load_year,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_second,
  output logic [5:0] out_minute,
  output logic [4:0] out_hour,
  output logic [2:0] out_weekday,
  output logic [4:0] out_day,
  output logic [3:0] out_month,
  output logic [6:0] out_year,
  output logic [1:0] out_wake_state,
  output logic [7:0] out_wake_ticks_left,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  logic [1:0]           s1_op_r;
  rtcwt_pkg::cal_time_t s1_load_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  rtcwt_pkg::cal_time_t out_cal_r;
  logic [1:0]           out_wstate_r;
  logic [1:0]           out_wstate_nxt;
  logic [7:0]           out_ticks_r;
  logic [7:0]           out_ticks_nxt;
  logic                 in_accept;
  logic                 adv;
  rtcwt_pkg::cmd_t      cmd;
  rtcwt_pkg::cal_time_t cal_nxt;
  logic [7:0]           timer_nxt;

  assign adv           = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall      = s1_valid_r & ~adv;
  assign in_accept     = in_valid & ~in_stall;
  assign s1_valid_nxt  = in_accept | (s1_valid_r & ~adv);
  assign out_valid_nxt = adv | (out_valid_r & out_stall);
  assign cmd.en        = adv;
  assign cmd.op        = s1_op_r;

  rtcwt_calendar u_cal (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .load    (s1_load_r),
    .cal_nxt (cal_nxt)
  );

  rtcwt_wake u_wake (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .timer_nxt   (timer_nxt)
  );

  always_comb begin
    if (timer_nxt == 8'd0) begin
      out_wstate_nxt = rtcwt_pkg::WAKE_OFF;
      out_ticks_nxt  = 8'd0;
    end else if (timer_nxt == rtcwt_pkg::WAKE_JUST_WOKE) begin
      out_wstate_nxt = rtcwt_pkg::WAKE_JUST;
      out_ticks_nxt  = 8'd0;
    end else begin
      out_wstate_nxt = rtcwt_pkg::WAKE_AWAKE;
      out_ticks_nxt  = timer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r         <= in_opcode;
      s1_load_r.sec   <= in_load_second;
      s1_load_r.min   <= in_load_minute;
      s1_load_r.hour  <= in_load_hour;
      s1_load_r.wday  <= in_load_weekday;
      s1_load_r.day   <= in_load_day;
      s1_load_r.month <= in_load_month;
      s1_load_r.year  <= in_load_year;
    end
    if (adv) begin
      out_cal_r    <= cal_nxt;
      out_wstate_r <= out_wstate_nxt;
      out_ticks_r  <= out_ticks_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_second          = out_cal_r.sec;
  assign out_minute          = out_cal_r.min;
  assign out_hour            = out_cal_r.hour;
  assign out_weekday         = out_cal_r.wday;
  assign out_day             = out_cal_r.day;
  assign out_month           = out_cal_r.month;
  assign out_year            = out_cal_r.year;
  assign out_wake_state      = out_wstate_r;
  assign out_wake_ticks_left = out_ticks_r;

endmodule

FILE: rtl/rtcwt_checker.sv
// ----------------------------------------------------------------------------
// rtcwt_checker
// Port-level checks of the calendar clock, bound to the top level.
// ----------------------------------------------------------------------------
module rtcwt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] out_second,
  input logic [5:0] out_minute,
  input logic [4:0] out_hour,
  input logic [1:0] out_wake_state,
  input logic [7:0] out_wake_ticks_left
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_second)
      && $stable(out_wake_ticks_left))
    else $error("stalled result changed");

  a_ticks_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake_state != rtcwt_pkg::WAKE_AWAKE |-> out_wake_ticks_left == 8'd0)
    else $error("ticks left while display not awake");

  a_ticks_awake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake_state == rtcwt_pkg::WAKE_AWAKE
      |-> out_wake_ticks_left != 8'd0 && out_wake_ticks_left != rtcwt_pkg::WAKE_JUST_WOKE)
    else $error("awake with bad tick count");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_second <= rtcwt_pkg::SEC_MAX && out_minute <= rtcwt_pkg::MIN_MAX
      && out_hour <= rtcwt_pkg::HOUR_MAX)
    else $error("time of day out of range");

endmodule

bind rtc_calendar_with_wake_timer rtcwt_checker u_rtcwt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_second          (out_second),
  .out_minute          (out_minute),
  .out_hour            (out_hour),
  .out_wake_state      (out_wake_state),
  .out_wake_ticks_left (out_wake_ticks_left)
);

FILE: bench/tb_rtc_calendar_with_wake_timer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtc_calendar_with_wake_timer
// Self-checking bench for the calendar clock with display wake timer.
// Requests come from a backlog queue and go out through a clocked driver. Each
// accepted request runs through a local calendar and wake timer that predict
// the time and wake status the block should report. A clocked monitor
// compares every returned result with the oldest prediction, field by field.
// A directed opening covers the field extremes, every opcode and the rollover
// corner cases. Random traffic follows, mostly loads just before a rollover
// followed by ticks, with the wake timeout changed between phases.
// ----------------------------------------------------------------------------
module tb_rtc_calendar_with_wake_timer;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] wday;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } rtc_req_t;

  typedef struct packed {
    rtcwt_pkg::cal_time_t cal;
    logic [1:0]           wake_state;
    logic [7:0]           wake_left;
  } rtc_view_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  rtc_req_t   in_req = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [5:0] out_second;
  logic [5:0] out_minute;
  logic [4:0] out_hour;
  logic [2:0] out_weekday;
  logic [4:0] out_day;
  logic [3:0] out_month;
  logic [6:0] out_year;
  logic [1:0] out_wake_state;
  logic [7:0] out_wake_ticks_left;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  rtc_req_t             pending_reqs[$];
  rtc_view_t            views_due[$];
  rtc_view_t            want;
  rtcwt_pkg::cal_time_t cal_now = rtcwt_pkg::CAL_RST;
  logic [7:0]           wake_cnt = rtcwt_pkg::WAKE_TIMER_RST;
  logic [7:0]           wake_limit = rtcwt_pkg::WAKE_MAX_RST;
  logic [4:0] days_in_month [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                     5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
  int         send_idle_pct = 29;
  int         recv_stall_pct = 47;
  int         mismatches = 0;
  int         cycles = 0;
  logic       hold_tgl = 1'b0;
  logic       hold_seen;
  int         hold_left;

  rtc_calendar_with_wake_timer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_req.op),
    .in_load_hour        (in_req.hour),
    .in_load_minute      (in_req.minute),
    .in_load_second      (in_req.second),
    .in_load_weekday     (in_req.wday),
    .in_load_day         (in_req.day),
    .in_load_month       (in_req.month),
    .in_load_year        (in_req.year),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_second          (out_second),
    .out_minute          (out_minute),
    .out_hour            (out_hour),
    .out_weekday         (out_weekday),
    .out_day             (out_day),
    .out_month           (out_month),
    .out_year            (out_year),
    .out_wake_state      (out_wake_state),
    .out_wake_ticks_left (out_wake_ticks_left),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Calendar and wake timer after one request.
  function automatic rtc_view_t advance_rtc(input rtc_req_t rq);
    rtc_view_t  v;
    logic [4:0] mlen;
    case (rq.op)
      rtcwt_pkg::OP_TICK: begin
        if (cal_now.sec != rtcwt_pkg::SEC_MAX) begin
          cal_now.sec = cal_now.sec + 6'd1;
        end else begin
          cal_now.sec = '0;
          if (cal_now.min != rtcwt_pkg::MIN_MAX) begin
            cal_now.min = cal_now.min + 6'd1;
          end else begin
            cal_now.min = '0;
            if (cal_now.hour != rtcwt_pkg::HOUR_MAX) begin
              cal_now.hour = cal_now.hour + 5'd1;
            end else begin
              cal_now.hour = '0;
              cal_now.wday = (cal_now.wday == rtcwt_pkg::WDAY_MAX) ? 3'd0
                                                                   : cal_now.wday + 3'd1;
              mlen = (cal_now.month == rtcwt_pkg::MONTH_FEB && cal_now.year[1:0] == 2'd0) ?
                     rtcwt_pkg::FEB_LEAP_DAYS : days_in_month[cal_now.month];
              if (cal_now.day < mlen) begin
                cal_now.day = cal_now.day + 5'd1;
              end else begin
                cal_now.day = rtcwt_pkg::DAY_MIN;
                if (cal_now.month != rtcwt_pkg::MONTH_MAX) begin
                  cal_now.month = cal_now.month + 4'd1;
                end else begin
                  cal_now.month = '0;
                  cal_now.year = (cal_now.year == rtcwt_pkg::YEAR_MAX) ? 7'd0
                                                                       : cal_now.year + 7'd1;
                end
              end
            end
          end
        end
        if (wake_cnt >= 8'd1 && wake_cnt <= wake_limit) wake_cnt = wake_cnt - 8'd1;
      end
      rtcwt_pkg::OP_BUTTON: begin
        wake_cnt = (wake_cnt == 8'd0) ? rtcwt_pkg::WAKE_JUST_WOKE : wake_limit;
      end
      rtcwt_pkg::OP_LOAD: begin
        cal_now.hour  = (rq.hour > rtcwt_pkg::HOUR_MAX) ? rtcwt_pkg::HOUR_MAX : rq.hour;
        cal_now.min   = (rq.minute > rtcwt_pkg::MIN_MAX) ? rtcwt_pkg::MIN_MAX : rq.minute;
        cal_now.sec   = (rq.second > rtcwt_pkg::SEC_MAX) ? rtcwt_pkg::SEC_MAX : rq.second;
        cal_now.wday  = (rq.wday > rtcwt_pkg::WDAY_MAX) ? rtcwt_pkg::WDAY_MAX : rq.wday;
        cal_now.day   = (rq.day < rtcwt_pkg::DAY_MIN) ? rtcwt_pkg::DAY_MIN : rq.day;
        cal_now.month = (rq.month > rtcwt_pkg::MONTH_MAX) ? rtcwt_pkg::MONTH_MAX : rq.month;
        cal_now.year  = (rq.year > rtcwt_pkg::YEAR_MAX) ? rtcwt_pkg::YEAR_MAX : rq.year;
      end
      default: begin
        if (wake_cnt == rtcwt_pkg::WAKE_JUST_WOKE) wake_cnt = wake_limit;
      end
    endcase
    v.cal = cal_now;
    if (wake_cnt == 8'd0) begin
      v.wake_state = rtcwt_pkg::WAKE_OFF;
      v.wake_left  = '0;
    end else if (wake_cnt == rtcwt_pkg::WAKE_JUST_WOKE) begin
      v.wake_state = rtcwt_pkg::WAKE_JUST;
      v.wake_left  = '0;
    end else begin
      v.wake_state = rtcwt_pkg::WAKE_AWAKE;
      v.wake_left  = wake_cnt;
    end
    return v;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < 200) $display("ERROR %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val)
      flag_mismatch($sformatf("%s got %0d want %0d", name, got, exp_val));
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) views_due.push_back(advance_rtc(in_req));
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_req   <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with an occasional long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen = hold_tgl;
      hold_left = 0;
    end else if (hold_seen != hold_tgl) begin
      hold_seen = hold_tgl;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (views_due.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        want = views_due.pop_front();
        check_field("second", int'(out_second), int'(want.cal.sec));
        check_field("minute", int'(out_minute), int'(want.cal.min));
        check_field("hour", int'(out_hour), int'(want.cal.hour));
        check_field("weekday", int'(out_weekday), int'(want.cal.wday));
        check_field("day", int'(out_day), int'(want.cal.day));
        check_field("month", int'(out_month), int'(want.cal.month));
        check_field("year", int'(out_year), int'(want.cal.year));
        check_field("wake_state", int'(out_wake_state), int'(want.wake_state));
        check_field("wake_ticks_left", int'(out_wake_ticks_left), int'(want.wake_left));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || views_due.size() > 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_wake_timeout(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    wake_limit = (v < rtcwt_pkg::WAKE_MAX_LO) ? rtcwt_pkg::WAKE_MAX_LO :
                 (v > rtcwt_pkg::WAKE_MAX_HI) ? rtcwt_pkg::WAKE_MAX_HI : v;
  endtask

  task automatic push_op(input logic [1:0] op);
    rtc_req_t rq;
    rq    = '0;
    rq.op = op;
    pending_reqs.push_back(rq);
  endtask

  task automatic push_load(input int h, input int m, input int s, input int w,
                           input int d, input int mo, input int y);
    rtc_req_t rq;
    rq.op     = rtcwt_pkg::OP_LOAD;
    rq.hour   = 5'(h);
    rq.minute = 6'(m);
    rq.second = 6'(s);
    rq.wday   = 3'(w);
    rq.day    = 5'(d);
    rq.month  = 4'(mo);
    rq.year   = 7'(y);
    pending_reqs.push_back(rq);
  endtask

  // Mostly loads just short of a rollover followed by ticks; the rest is
  // random requests over the full field widths.
  task automatic queue_random(input int count);
    rtc_req_t rq;
    int       k;
    int       r;
    while (count > 0) begin
      rq.op     = 2'($urandom_range(3));
      rq.hour   = 5'($urandom_range(31));
      rq.minute = 6'($urandom_range(63));
      rq.second = 6'($urandom_range(63));
      rq.wday   = 3'($urandom_range(7));
      rq.day    = 5'($urandom_range(31));
      rq.month  = 4'($urandom_range(15));
      rq.year   = 7'($urandom_range(127));
      if ($urandom_range(99) < 60) begin
        rq.op = rtcwt_pkg::OP_LOAD;
        if ($urandom_range(3) != 0) rq.hour = rtcwt_pkg::HOUR_MAX;
        if ($urandom_range(9) != 0) rq.minute = rtcwt_pkg::MIN_MAX;
        rq.second = 6'($urandom_range(52, 59));
        if ($urandom_range(4) != 0) rq.day = 5'($urandom_range(27, 31));
        if ($urandom_range(9) != 0)
          rq.month = ($urandom_range(3) == 0) ? rtcwt_pkg::MONTH_MAX : 4'($urandom_range(11));
        if ($urandom_range(9) != 0)
          rq.year = ($urandom_range(3) == 0) ? rtcwt_pkg::YEAR_MAX : 7'($urandom_range(99));
        pending_reqs.push_back(rq);
        count--;
        k = $urandom_range(3, 10);
        repeat (k) begin
          r     = $urandom_range(99);
          rq.op = (r < 80) ? rtcwt_pkg::OP_TICK :
                  (r < 90) ? rtcwt_pkg::OP_BUTTON : rtcwt_pkg::OP_ACK;
          rq.hour = 5'($urandom_range(31));
          pending_reqs.push_back(rq);
          count--;
        end
      end else begin
        pending_reqs.push_back(rq);
        count--;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_op(rtcwt_pkg::OP_TICK);
    push_op(rtcwt_pkg::OP_BUTTON);
    push_op(rtcwt_pkg::OP_ACK);
    push_load(23, 59, 59, 6, 31, 11, 99);
    push_op(rtcwt_pkg::OP_TICK);
    push_load(31, 63, 63, 7, 31, 15, 127);
    push_load(0, 0, 0, 0, 0, 0, 0);
    push_load(23, 59, 59, 2, 28, 1, 24);
    push_op(rtcwt_pkg::OP_TICK);
    push_load(23, 59, 59, 3, 29, 1, 23);
    push_op(rtcwt_pkg::OP_TICK);
    push_load(23, 59, 59, 4, 31, 1, 24);
    push_op(rtcwt_pkg::OP_TICK);
    push_load(23, 59, 59, 5, 30, 3, 50);
    repeat (5) push_op(rtcwt_pkg::OP_TICK);
    push_op(rtcwt_pkg::OP_BUTTON);
    push_op(rtcwt_pkg::OP_TICK);
    push_op(rtcwt_pkg::OP_ACK);
    push_op(rtcwt_pkg::OP_BUTTON);
    wait_drained();

    // timer left above a lowered timeout
    set_wake_timeout(8'd0);
    queue_random(210);
    wait_drained();
    queue_random(210);
    wait_drained();

    set_wake_timeout(8'hFF);
    send_idle_pct  <= 47;
    recv_stall_pct <= 29;
    queue_random(420);
    wait_drained();

    set_wake_timeout(8'($urandom_range(2, 12)));
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    queue_random(410);
    repeat (30) @(posedge clk);
    hold_tgl <= ~hold_tgl;
    wait_drained();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
